/* src/hsv2rgb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants, sector codes and stage records for the HSV to RGB pipe.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_W = 9;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned REM_W = 6;
  localparam int unsigned FAC_W = 14;
  localparam int unsigned XP_W  = 16;
  localparam int unsigned XQ_W  = 22;
  localparam int unsigned XD_W  = 20;

  localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;
  localparam logic [HUE_W-1:0] DEG_SECTOR = 9'd60;
  localparam logic [CH_W-1:0]  FULL_SCALE = 8'd255;
  localparam logic [FAC_W-1:0] FINE_SCALE = 14'd15300;

  // x/255 for 16-bit x: (x * 0x8081) >> 23, exact over the whole range
  localparam logic [15:0] P_RECIP = 16'h8081;
  localparam int unsigned P_SHIFT = 23;

  // x/15300 = (x>>2)/3825; floor reciprocal is exact or one short
  localparam logic [20:0] QT_RECIP   = 21'd1122867;
  localparam logic [11:0] QT_DIVISOR = 12'd3825;
  localparam int unsigned QT_SHIFT   = 32;

  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic             grey;
    sector_t          sector;
    logic [REM_W-1:0] rem;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } sec_t;

  typedef struct packed {
    logic             grey;
    sector_t          sector;
    logic [CH_W-1:0]  val;
    logic [CH_W-1:0]  np;
    logic [FAC_W-1:0] nq;
    logic [FAC_W-1:0] nt;
  } fac_t;

  typedef struct packed {
    logic            grey;
    sector_t         sector;
    logic [CH_W-1:0] val;
    logic [XP_W-1:0] xp;
    logic [XQ_W-1:0] xq;
    logic [XQ_W-1:0] xt;
  } prd_t;

  typedef struct packed {
    logic            grey;
    sector_t         sector;
    logic [CH_W-1:0] val;
    logic [CH_W-1:0] p;
    logic [CH_W-1:0] q0;
    logic [CH_W-1:0] t0;
    logic [XD_W-1:0] xq;
    logic [XD_W-1:0] xt;
  } quo_t;

endpackage
`default_nettype wire

/* src/hsv2rgb_sector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Stage 1: hue wrap, sector and remainder within the sector.
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    sat,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    val,
  output logic                            vld_r,
  output hsv2rgb_pkg::sec_t               sec_r
);

  localparam logic [hsv2rgb_pkg::HUE_W-1:0] B1 = hsv2rgb_pkg::DEG_SECTOR;
  localparam logic [hsv2rgb_pkg::HUE_W-1:0] B2 = 9'(2 * hsv2rgb_pkg::DEG_SECTOR);
  localparam logic [hsv2rgb_pkg::HUE_W-1:0] B3 = 9'(3 * hsv2rgb_pkg::DEG_SECTOR);
  localparam logic [hsv2rgb_pkg::HUE_W-1:0] B4 = 9'(4 * hsv2rgb_pkg::DEG_SECTOR);
  localparam logic [hsv2rgb_pkg::HUE_W-1:0] B5 = 9'(5 * hsv2rgb_pkg::DEG_SECTOR);

  logic [hsv2rgb_pkg::HUE_W-1:0] h;
  logic [hsv2rgb_pkg::HUE_W-1:0] base;
  hsv2rgb_pkg::sector_t          sector;
  hsv2rgb_pkg::sec_t             sec_nxt;

  always_comb begin
    // 360..511 fold back onto 0..151
    h = (hue >= hsv2rgb_pkg::HUE_WRAP) ? hue - hsv2rgb_pkg::HUE_WRAP : hue;
    if (h >= B5) begin
      sector = hsv2rgb_pkg::SEC_M_R;
      base   = B5;
    end else if (h >= B4) begin
      sector = hsv2rgb_pkg::SEC_B_M;
      base   = B4;
    end else if (h >= B3) begin
      sector = hsv2rgb_pkg::SEC_C_B;
      base   = B3;
    end else if (h >= B2) begin
      sector = hsv2rgb_pkg::SEC_G_C;
      base   = B2;
    end else if (h >= B1) begin
      sector = hsv2rgb_pkg::SEC_Y_G;
      base   = B1;
    end else begin
      sector = hsv2rgb_pkg::SEC_R_Y;
      base   = '0;
    end
    sec_nxt.grey   = (sat == '0);
    sec_nxt.sector = sector;
    sec_nxt.rem    = hsv2rgb_pkg::REM_W'(h - base);
    sec_nxt.sat    = sat;
    sec_nxt.val    = val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec_r <= sec_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/hsv2rgb_mult.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_mult
// Stages 2 and 3: saturation factors, then scaling by the value channel.
// ----------------------------------------------------------------------------
module hsv2rgb_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        en,      // [0] factor stage, [1] product stage
  input  logic              in_vld,
  input  hsv2rgb_pkg::sec_t sec,
  output logic [1:0]        vld_r,
  output hsv2rgb_pkg::prd_t prd_r
);

  hsv2rgb_pkg::fac_t                  fac_r;
  hsv2rgb_pkg::fac_t                  fac_nxt;
  hsv2rgb_pkg::prd_t                  prd_nxt;
  logic [hsv2rgb_pkg::REM_W-1:0]      rem_inv;
  logic [hsv2rgb_pkg::FAC_W-1:0]      s_rem;
  logic [hsv2rgb_pkg::FAC_W-1:0]      s_inv;

  always_comb begin
    rem_inv = hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::DEG_SECTOR) - sec.rem;
    s_rem   = {6'd0, sec.sat} * {8'd0, sec.rem};
    s_inv   = {6'd0, sec.sat} * {8'd0, rem_inv};
    fac_nxt.grey   = sec.grey;
    fac_nxt.sector = sec.sector;
    fac_nxt.val    = sec.val;
    fac_nxt.np     = hsv2rgb_pkg::FULL_SCALE - sec.sat;
    fac_nxt.nq     = hsv2rgb_pkg::FINE_SCALE - s_rem;
    fac_nxt.nt     = hsv2rgb_pkg::FINE_SCALE - s_inv;
  end

  always_comb begin
    prd_nxt.grey   = fac_r.grey;
    prd_nxt.sector = fac_r.sector;
    prd_nxt.val    = fac_r.val;
    prd_nxt.xp     = {8'd0, fac_r.val} * {8'd0, fac_r.np};
    prd_nxt.xq     = {14'd0, fac_r.val} * {8'd0, fac_r.nq};
    prd_nxt.xt     = {14'd0, fac_r.val} * {8'd0, fac_r.nt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) fac_r <= fac_nxt;
    if (en[1]) prd_r <= prd_nxt;
  end

endmodule
`default_nettype wire

/* src/hsv2rgb_divide.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_divide
// Stages 4 and 5: reciprocal division, one-step correction, channel order.
// ----------------------------------------------------------------------------
module hsv2rgb_divide (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    en,      // [0] quotient, [1] output
  input  logic                          in_vld,
  input  hsv2rgb_pkg::prd_t             prd,
  output logic [1:0]                    vld_r,
  output logic [hsv2rgb_pkg::CH_W-1:0]  red_r,
  output logic [hsv2rgb_pkg::CH_W-1:0]  green_r,
  output logic [hsv2rgb_pkg::CH_W-1:0]  blue_r
);

  hsv2rgb_pkg::quo_t              quo_r;
  hsv2rgb_pkg::quo_t              quo_nxt;
  logic [31:0]                    p_prod;
  logic [40:0]                    q_prod;
  logic [40:0]                    t_prod;
  logic [hsv2rgb_pkg::XD_W-1:0]   q_back;
  logic [hsv2rgb_pkg::XD_W-1:0]   t_back;
  logic [hsv2rgb_pkg::XD_W-1:0]   q_res;
  logic [hsv2rgb_pkg::XD_W-1:0]   t_res;
  logic [hsv2rgb_pkg::CH_W-1:0]   q;
  logic [hsv2rgb_pkg::CH_W-1:0]   t;
  logic [hsv2rgb_pkg::CH_W-1:0]   red_nxt;
  logic [hsv2rgb_pkg::CH_W-1:0]   green_nxt;
  logic [hsv2rgb_pkg::CH_W-1:0]   blue_nxt;

  always_comb begin
    p_prod = {16'd0, prd.xp} * {16'd0, hsv2rgb_pkg::P_RECIP};
    q_prod = {21'd0, prd.xq[hsv2rgb_pkg::XQ_W-1:2]} * {20'd0, hsv2rgb_pkg::QT_RECIP};
    t_prod = {21'd0, prd.xt[hsv2rgb_pkg::XQ_W-1:2]} * {20'd0, hsv2rgb_pkg::QT_RECIP};
    quo_nxt.grey   = prd.grey;
    quo_nxt.sector = prd.sector;
    quo_nxt.val    = prd.val;
    quo_nxt.p      = p_prod[hsv2rgb_pkg::P_SHIFT +: hsv2rgb_pkg::CH_W];
    quo_nxt.q0     = q_prod[hsv2rgb_pkg::QT_SHIFT +: hsv2rgb_pkg::CH_W];
    quo_nxt.t0     = t_prod[hsv2rgb_pkg::QT_SHIFT +: hsv2rgb_pkg::CH_W];
    quo_nxt.xq     = prd.xq[hsv2rgb_pkg::XQ_W-1:2];
    quo_nxt.xt     = prd.xt[hsv2rgb_pkg::XQ_W-1:2];
  end

  always_comb begin
    // estimate is exact or one short; remainder check fixes it
    q_back = {12'd0, quo_r.q0} * {8'd0, hsv2rgb_pkg::QT_DIVISOR};
    t_back = {12'd0, quo_r.t0} * {8'd0, hsv2rgb_pkg::QT_DIVISOR};
    q_res  = quo_r.xq - q_back;
    t_res  = quo_r.xt - t_back;
    q = (q_res >= {8'd0, hsv2rgb_pkg::QT_DIVISOR}) ? quo_r.q0 + 8'd1 : quo_r.q0;
    t = (t_res >= {8'd0, hsv2rgb_pkg::QT_DIVISOR}) ? quo_r.t0 + 8'd1 : quo_r.t0;

    case (quo_r.sector)
      hsv2rgb_pkg::SEC_R_Y: begin
        red_nxt = quo_r.val; green_nxt = t;         blue_nxt = quo_r.p;
      end
      hsv2rgb_pkg::SEC_Y_G: begin
        red_nxt = q;         green_nxt = quo_r.val; blue_nxt = quo_r.p;
      end
      hsv2rgb_pkg::SEC_G_C: begin
        red_nxt = quo_r.p;   green_nxt = quo_r.val; blue_nxt = t;
      end
      hsv2rgb_pkg::SEC_C_B: begin
        red_nxt = quo_r.p;   green_nxt = q;         blue_nxt = quo_r.val;
      end
      hsv2rgb_pkg::SEC_B_M: begin
        red_nxt = t;         green_nxt = quo_r.p;   blue_nxt = quo_r.val;
      end
      default: begin
        red_nxt = quo_r.val; green_nxt = quo_r.p;   blue_nxt = q;
      end
    endcase

    if (quo_r.grey) begin
      red_nxt   = quo_r.val;
      green_nxt = quo_r.val;
      blue_nxt  = quo_r.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) quo_r <= quo_nxt;
    if (en[1]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/hsv_to_rgb_convert.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// HSV to RGB pixel converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// Converts one pixel per clock while in_stall is low: a new transaction is taken
// every such cycle and passes through the pipeline stages in order (sector split,
// saturation factors, value products, reciprocal division, correction and
// channel order), each of which registers it, before it sits on the outputs.
// Each stage holds only while the stage after it is full and stalled, so a
// stalled output fills the pipe before in_stall rises and gaps in the input
// stream are squeezed out. Hue values from 360 up wrap back by 360; zero
// saturation gives grey at the value level.
module hsv_to_rgb_convert (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   in_hue,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    in_saturation,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    in_brightness,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsv2rgb_pkg::CH_W-1:0]    out_red,
  output logic [hsv2rgb_pkg::CH_W-1:0]    out_green,
  output logic [hsv2rgb_pkg::CH_W-1:0]    out_blue
);

  logic              vld1;
  logic [1:0]        vld23;
  logic [1:0]        vld45;
  logic [5:1]        en;
  hsv2rgb_pkg::sec_t sec;
  hsv2rgb_pkg::prd_t prd;

  // a stage loads when empty or when the next one moves on
  always_comb begin
    en[5] = !vld45[1] || !out_stall;
    en[4] = !vld45[0] || en[5];
    en[3] = !vld23[1] || en[4];
    en[2] = !vld23[0] || en[3];
    en[1] = !vld1     || en[2];
  end

  assign in_stall  = !en[1];
  assign out_valid = vld45[1];

  hsv2rgb_sector u_sector (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[1]),
    .in_vld (in_valid),
    .hue    (in_hue),
    .sat    (in_saturation),
    .val    (in_brightness),
    .vld_r  (vld1),
    .sec_r  (sec)
  );

  hsv2rgb_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[3:2]),
    .in_vld (vld1),
    .sec    (sec),
    .vld_r  (vld23),
    .prd_r  (prd)
  );

  hsv2rgb_divide u_divide (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en[5:4]),
    .in_vld  (vld23[1]),
    .prd     (prd),
    .vld_r   (vld45),
    .red_r   (out_red),
    .green_r (out_green),
    .blue_r  (out_blue)
  );

endmodule
`default_nettype wire

/* src/hsv2rgb_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    in_saturation,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    in_brightness,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    out_red,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    out_green,
  input  logic [hsv2rgb_pkg::CH_W-1:0]    out_blue
);

  localparam int unsigned LAT = 5;

  logic in_acc;
  logic flow;

  assign in_acc = in_valid && !in_stall;
  assign flow   = rst_n && !out_stall;

  // a transaction accepted at the input, with the output never held since
  sequence pix_through;
    $past(in_acc, LAT) && $past(rst_n, LAT) &&
    $past(flow, 1) && $past(flow, 2) &&
    $past(flow, 3) && $past(flow, 4);
  endsequence

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) &&
                               $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    pix_through |-> out_valid)
    else $error("free-flowing transaction missing after pipeline delay");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    pix_through ##0 ($past(in_saturation, LAT) == '0) |->
      out_red == $past(in_brightness, LAT) &&
      out_green == $past(in_brightness, LAT) &&
      out_blue == $past(in_brightness, LAT))
    else $error("zero saturation did not give grey");

endmodule

bind hsv_to_rgb_convert hsv2rgb_checker u_hsv2rgb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_saturation (in_saturation),
  .in_brightness (in_brightness),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);
`default_nettype wire
